>>> rtl/kvm_pkg.sv
// ----------------------------------------------------------------------------
// kvm_pkg: shared types for the key/value table
// Sequencer states, command and status codes, and memory write controls.
// ----------------------------------------------------------------------------
package kvm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESPOND
   } state_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_HIT       = 2'd0,
      STATUS_INSERTED  = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic key_we;
      logic value_we;
   } mem_ctl_type;

endpackage

>>> rtl/key_value_map_linear_search.sv
// A request is accepted in idle and walks the stored entries in the search
// state with the single key comparator fed from one memory read port, then
// waits in the respond state until the response register is free. No new
// request is accepted until the last one has been loaded into that register.
// Reset clears the entry count and the control state; the memories keep
// their contents, and entries beyond the count are never compared.
// ----------------------------------------------------------------------------
// key_value_map_linear_search: bounded key/value table with linear search
// Entries are kept in insertion order. A write updates a matching entry, else
// appends one if room is left; a read hit returns the value with found status.
// ----------------------------------------------------------------------------
module key_value_map_linear_search #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [VALUE_BITS-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [VALUE_BITS-1:0]   rsp_read_value,
   output logic [CNT_BITS-1:0]     rsp_entry_count
);

   // Memory interface between the sequencer and the storage arrays.
   kvm_pkg::mem_ctl_type  mem_ctl;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;
   logic [KEY_BITS-1:0]   key_rd;
   logic [VALUE_BITS-1:0] value_rd;

   // Finished result from the sequencer, loaded into the response register.
   logic                  out_free;
   logic                  res_load;
   kvm_pkg::status_type   res_status;
   logic [VALUE_BITS-1:0] res_value;
   logic [CNT_BITS-1:0]   res_count;

   // Response register: holds one result until the consumer takes it, so
   // the sequencer can go back to idle and accept the next request.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_read_value_ff;
   logic [CNT_BITS-1:0]   rsp_entry_count_ff;

   kvm_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_store (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .rd_addr  (rd_addr),
      .key_rd   (key_rd),
      .value_rd (value_rd)
   );

   kvm_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .req_value  (req_value),
      .key_rd     (key_rd),
      .value_rd   (value_rd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_key     (wr_key),
      .wr_value   (wr_value),
      .mem_ctl    (mem_ctl),
      .out_free   (out_free),
      .res_load   (res_load),
      .res_status (res_status),
      .res_value  (res_value),
      .res_count  (res_count)
   );

   // The register is free when empty or when its result leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status_ff      <= res_status;
         rsp_read_value_ff  <= res_value;
         rsp_entry_count_ff <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while occupied");

   // The reported count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_entry_count_ff <= CNT_BITS'(TABLE_DEPTH)))
      else $error("entry count above table depth");

endmodule

>>> rtl/kvm_store.sv
// ----------------------------------------------------------------------------
// kvm_store: key and value memories
// One write port and one registered read port, shared address for both arrays.
// ----------------------------------------------------------------------------
module kvm_store #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   localparam int IDX_BITS   = $clog2(TABLE_DEPTH)
) (
   input  logic                    clock,
   input  kvm_pkg::mem_ctl_type    mem_ctl,
   input  logic [IDX_BITS-1:0]     wr_addr,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [VALUE_BITS-1:0]   wr_value,
   input  logic [IDX_BITS-1:0]     rd_addr,
   output logic [KEY_BITS-1:0]     key_rd,
   output logic [VALUE_BITS-1:0]   value_rd
);

   logic [KEY_BITS-1:0]   key_mem   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.value_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   assign key_rd   = key_rd_ff;
   assign value_rd = value_rd_ff;

endmodule

>>> rtl/kvm_ctrl.sv
// ----------------------------------------------------------------------------
// kvm_ctrl: search sequencer and key comparator
// Walks the stored entries one per cycle, then updates, appends or answers.
// ----------------------------------------------------------------------------
module kvm_ctrl #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  logic [KEY_BITS-1:0]     key_rd,
   input  logic [VALUE_BITS-1:0]   value_rd,
   output logic [IDX_BITS-1:0]     rd_addr,
   output logic [IDX_BITS-1:0]     wr_addr,
   output logic [KEY_BITS-1:0]     wr_key,
   output logic [VALUE_BITS-1:0]   wr_value,
   output kvm_pkg::mem_ctl_type    mem_ctl,
   input  logic                    out_free,
   output logic                    res_load,
   output kvm_pkg::status_type     res_status,
   output logic [VALUE_BITS-1:0]   res_value,
   output logic [CNT_BITS-1:0]     res_count
);

   kvm_pkg::state_type  state_ff, state_in;
   kvm_pkg::cmd_type    cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   kvm_pkg::status_type   res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;

   logic accept;
   logic issue;
   logic hit;
   logic done;
   logic has_room;

   // A read is in flight for pend_idx_ff; its key is compared this cycle.
   assign accept   = req_valid && req_ready;
   assign issue    = (idx_ff < count_ff);
   assign hit      = pend_ff && (key_rd == key_ff);
   assign done     = (state_ff == kvm_pkg::ST_SEARCH) && (hit || !issue);
   assign has_room = (count_ff != CNT_BITS'(TABLE_DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kvm_pkg::ST_SEARCH;
            end
         end
         kvm_pkg::ST_SEARCH: begin
            if (done) begin
               state_in = kvm_pkg::ST_RESPOND;
            end
         end
         kvm_pkg::ST_RESPOND: begin
            if (out_free) begin
               state_in = kvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      res_load  = 1'b0;
      mem_ctl   = '0;
      rd_addr   = idx_ff[IDX_BITS-1:0];
      wr_addr   = pend_idx_ff;
      wr_key    = key_ff;
      wr_value  = value_ff;
      case (state_ff)
         kvm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         kvm_pkg::ST_SEARCH: begin
            if (done && (cmd_ff == kvm_pkg::CMD_WRITE)) begin
               if (hit) begin
                  mem_ctl.value_we = 1'b1;
               end else if (has_room) begin
                  mem_ctl.key_we   = 1'b1;
                  mem_ctl.value_we = 1'b1;
                  wr_addr          = count_ff[IDX_BITS-1:0];
               end
            end
         end
         kvm_pkg::ST_RESPOND: begin
            res_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (accept) begin
         cmd_in   = kvm_pkg::cmd_type'(req_cmd);
         key_in   = req_key;
         value_in = req_value;
         idx_in   = '0;
         pend_in  = 1'b0;
      end
      if (state_ff == kvm_pkg::ST_SEARCH) begin
         idx_in      = idx_ff + CNT_BITS'(issue);
         pend_in     = issue;
         pend_idx_in = idx_ff[IDX_BITS-1:0];
      end
      if (done) begin
         res_value_in = '0;
         if (cmd_ff == kvm_pkg::CMD_READ) begin
            if (hit) begin
               res_status_in = kvm_pkg::STATUS_HIT;
               res_value_in  = value_rd;
            end else begin
               res_status_in = kvm_pkg::STATUS_NOT_FOUND;
            end
         end else if (hit) begin
            res_status_in = kvm_pkg::STATUS_HIT;
         end else if (has_room) begin
            res_status_in = kvm_pkg::STATUS_INSERTED;
            count_in      = count_ff + 1'b1;
         end else begin
            res_status_in = kvm_pkg::STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvm_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
   end

   assign res_status = res_status_ff;
   assign res_value  = res_value_ff;
   assign res_count  = count_ff;

   // Memory writes happen only at the end of a write request's search.
   a_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.key_we || mem_ctl.value_we) |->
         (state_ff == kvm_pkg::ST_SEARCH) && (cmd_ff == kvm_pkg::CMD_WRITE))
      else $error("table written outside a write search");

   // A new key is appended only on a miss with room left.
   a_append_on_miss: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.key_we |-> (!hit && has_room && mem_ctl.value_we))
      else $error("key appended on a hit or into a full table");

   // The entry count only ever grows by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == CNT_BITS'($past(count_ff) + 1'b1)))
      else $error("entry count changed by other than one");

endmodule
